// File: design/tnc_pkg.sv
`timescale 1ns / 1ps
package tnc_pkg;
   localparam int DataWidth  = 64;
   localparam int HalfWidth  = DataWidth / 2;
   localparam int RateWidth  = 34;
   localparam int RemWidth   = 34;
   localparam int DivSteps   = DataWidth;
   localparam int NumCells   = 2 * DivSteps + 3;
   localparam logic [29:0] NsPerSec = 30'd1000000000;
   localparam logic [RateWidth-1:0] RateReset = 34'd1000000000;

   typedef enum logic [1:0] {
      MODE_TICK_TO_RT = 2'd0,
      MODE_RT_TO_TICK = 2'd1,
      MODE_DELTA_NS   = 2'd2,
      MODE_NS_TO_TICK = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_TICK_RATE = 2'd0,
      REG_TICK_EPOCH = 2'd1,
      REG_RT_EPOCH = 2'd2
   } reg_index_type;

   // state carried between division cells
   typedef struct packed {
      logic                  valid;
      logic                  scale;
      logic                  zero;
      logic [DataWidth-1:0]  base;
      logic [DataWidth-1:0]  num;
      logic [RemWidth:0]     rem;
      logic [RateWidth-1:0]  den;
      logic [DataWidth-1:0]  quo;
      logic [DataWidth-1:0]  hi;
   } cell_type;
endpackage

// File: design/tnc_stream_if.sv
`timescale 1ns / 1ps
interface tnc_stream_if #(parameter int Width = 1);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/tick_nanosecond_converter.sv
`timescale 1ns / 1ps
// Tick / nanosecond timestamp converter.
// req channel carries {mode, value_a, value_b}; rsp carries result_value.
// csr port writes tick_rate_hz (0), tick_epoch (1), realtime_epoch_ns (2);
// the user must write only while no transaction is in flight (unchecked).
// The conversion runs through a chain of cells: an input cell, 64 restoring
// division cells, two multiply cells (one per quotient half), 64 more
// division cells and a final add into the output register.
// Throughput is one transaction per cycle while the skid register is empty:
// each cell passes its stage to its neighbor every cycle, all in lockstep.
// When the receiver stalls the chain keeps moving until a second result
// arrives; that one lands in a skid register, and then the chain and req
// ready hold until the output drains.
// Reset (synchronous, active high) empties the chain and restores the
// registers to rate 1e9 and zero epochs.
module tick_nanosecond_converter
   import tnc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [DataWidth-1:0] csr_write_data,
   tnc_stream_if.sink   req,
   tnc_stream_if.source rsp
);
   logic [RateWidth-1:0] rate_ff;
   logic [DataWidth-1:0] tick_epoch_ff, rt_epoch_ff;
   cell_type chain [0:NumCells-1];
   cell_type head_in, head_ff;
   logic advance;
   logic out_valid_ff, skid_valid_ff;
   logic [DataWidth-1:0] out_data_ff, skid_data_ff, final_value;
   mode_type mode;
   logic [DataWidth-1:0] val_a, val_b;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RateReset;
         tick_epoch_ff <= '0;
         rt_epoch_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_TICK_RATE:  rate_ff <= csr_write_data[RateWidth-1:0];
            REG_TICK_EPOCH: tick_epoch_ff <= csr_write_data;
            REG_RT_EPOCH:   rt_epoch_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign mode  = mode_type'(req.data[2*DataWidth+1 -: 2]);
   assign val_a = req.data[2*DataWidth-1 -: DataWidth];
   assign val_b = req.data[DataWidth-1:0];

   // chain moves whenever the skid is empty
   assign advance = !skid_valid_ff;
   assign req.ready = advance;

   // input cell: operand select and epoch offsets
   always_comb begin
      head_in = '0;
      head_in.valid = req.valid;
      head_in.den = rate_ff;
      case (mode)
         MODE_TICK_TO_RT: begin
            head_in.scale = 1'b1;
            head_in.num = val_a - tick_epoch_ff;
            head_in.base = rt_epoch_ff;
            head_in.zero = (rate_ff == '0);
         end
         MODE_RT_TO_TICK: begin
            head_in.num = val_a - rt_epoch_ff;
            head_in.base = tick_epoch_ff;
            head_in.den = {4'd0, NsPerSec};
         end
         MODE_DELTA_NS: begin
            head_in.scale = 1'b1;
            head_in.num = val_a - val_b;
            head_in.zero = (rate_ff == '0) || (val_a <= val_b);
         end
         default: begin
            head_in.num = val_a;
            head_in.den = {4'd0, NsPerSec};
         end
      endcase
      if (!head_in.scale) begin
         head_in.hi = {30'd0, rate_ff};
      end
   end

   // in unscale mode the rate rides in hi until the multiply cells
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (advance) begin
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   genvar g;
   generate
      for (g = 0; g < NumCells - 1; g++) begin : g_cell
         if (g == DivSteps || g == DivSteps + 1) begin : g_mid
            tnc_mid_cell u_mid (.clock(clock), .reset(reset), .enable(advance),
               .low_half(g == DivSteps + 1), .cell_in(chain[g]), .cell_out(chain[g+1]));
         end else begin : g_div
            tnc_div_cell u_div (.clock(clock), .reset(reset), .enable(advance),
               .cell_in(chain[g]), .cell_out(chain[g+1]));
         end
      end
   endgenerate

   // final add of quotient product, remainder quotient and base
   assign final_value = chain[NumCells-1].zero ? chain[NumCells-1].base :
      chain[NumCells-1].base + chain[NumCells-1].hi + chain[NumCells-1].quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            if (out_valid_ff && !rsp.ready) begin
               skid_valid_ff <= chain[NumCells-1].valid;
            end else begin
               out_valid_ff <= chain[NumCells-1].valid;
            end
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (out_valid_ff && !rsp.ready) skid_data_ff <= final_value;
         else out_data_ff <= final_value;
      end else if (rsp.ready) begin
         out_data_ff <= skid_data_ff;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_data_ff;

   // skid only fills behind a stalled output
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff) else $error("skid without output");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |=> out_valid_ff) else $error("lost result");
   a_ready_skid: assert property (@(posedge clock) disable iff (reset)
      req.ready == !skid_valid_ff) else $error("ready mismatch");
endmodule

// File: design/tnc_div_cell.sv
`timescale 1ns / 1ps
module tnc_div_cell
   import tnc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     enable,
   input  cell_type cell_in,
   output cell_type cell_out
);
   cell_type cell_ff, cell_in_next;
   logic [RemWidth:0] shifted;
   logic [RemWidth+1:0] diff;

   // one restoring division step: bring in the next numerator bit
   always_comb begin
      cell_in_next = cell_in;
      shifted = {cell_in.rem[RemWidth-1:0], cell_in.num[DataWidth-1]};
      diff = {1'b0, shifted} - {2'b00, cell_in.den};
      cell_in_next.num = {cell_in.num[DataWidth-2:0], 1'b0};
      if (!diff[RemWidth+1]) begin
         cell_in_next.rem = diff[RemWidth:0];
         cell_in_next.quo = {cell_in.quo[DataWidth-2:0], 1'b1};
      end else begin
         cell_in_next.rem = shifted;
         cell_in_next.quo = {cell_in.quo[DataWidth-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;
endmodule

// File: design/tnc_mid_cell.sv
`timescale 1ns / 1ps
module tnc_mid_cell
   import tnc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     enable,
   input  logic     low_half,
   input  cell_type cell_in,
   output cell_type cell_out
);
   cell_type cell_ff, cell_in_next;
   logic [RateWidth-1:0] factor;
   logic [HalfWidth-1:0] quo_half;
   logic [HalfWidth+RateWidth-1:0] half_prod;
   logic [2*RateWidth-1:0] rem_prod;

   // quotient times the other factor, one half per cell;
   // the first cell also turns remainder times factor into the new numerator
   always_comb begin
      cell_in_next = cell_in;
      if (cell_in.scale) begin
         factor = {4'd0, NsPerSec};
      end else if (low_half) begin
         factor = cell_in.den;
      end else begin
         factor = cell_in.hi[RateWidth-1:0];
      end
      quo_half = low_half ? cell_in.quo[HalfWidth-1:0] : cell_in.quo[DataWidth-1:HalfWidth];
      half_prod = {{RateWidth{1'b0}}, quo_half} * {{HalfWidth{1'b0}}, factor};
      rem_prod = {{RateWidth{1'b0}}, cell_in.rem[RemWidth-1:0]} * {{RateWidth{1'b0}}, factor};
      if (!low_half) begin
         // upper quotient half only reaches the top 32 bits
         cell_in_next.hi  = {half_prod[HalfWidth-1:0], {HalfWidth{1'b0}}};
         cell_in_next.num = rem_prod[DataWidth-1:0];
         cell_in_next.rem = '0;
         if (!cell_in.scale) begin
            cell_in_next.den = factor;
         end
      end else begin
         cell_in_next.hi  = cell_in.hi + half_prod[DataWidth-1:0];
         cell_in_next.quo = '0;
         if (!cell_in.scale) begin
            cell_in_next.den = {4'd0, NsPerSec};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;
endmodule

// File: bench/tb_tick_nanosecond_converter.sv
`timescale 1ns / 1ps
module tb_tick_nanosecond_converter;
   import tnc_pkg::*;

   localparam logic [1:0] RegUnused = 2'd3;
   localparam logic [63:0] NsSec = 64'd1000000000;
   localparam int ChainCycles = 140;

   // expected conversions, in acceptance order
   class conversion_scoreboard;
      logic [63:0] rate;
      logic [63:0] tick_base;
      logic [63:0] rt_base;
      logic [63:0] pending_ns[$];
      int errors;

      function new();
         rate = 64'd1000000000;
         tick_base = '0;
         rt_base = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [63:0] value);
         case (idx)
            REG_TICK_RATE: rate = {30'd0, value[RateWidth-1:0]};
            REG_TICK_EPOCH: tick_base = value;
            REG_RT_EPOCH: rt_base = value;
            default: ;
         endcase
      endfunction

      function logic [63:0] ticks_to_ns(logic [63:0] d);
         if (rate == 0) return '0;
         return (d / rate) * NsSec + ((d % rate) * NsSec) / rate;
      endfunction

      function logic [63:0] ns_span_ticks(logic [63:0] d);
         return (d / NsSec) * rate + ((d % NsSec) * rate) / NsSec;
      endfunction

      function void note_request(mode_type m, logic [63:0] a, logic [63:0] b);
         logic [63:0] res;
         case (m)
            MODE_TICK_TO_RT: res = rt_base + ticks_to_ns(a - tick_base);
            MODE_RT_TO_TICK: res = tick_base + ns_span_ticks(a - rt_base);
            MODE_DELTA_NS: res = (a <= b) ? 64'd0 : ticks_to_ns(a - b);
            default: res = ns_span_ticks(a);
         endcase
         pending_ns.push_back(res);
      endfunction

      function void check_result(logic [63:0] actual);
         logic [63:0] exp_val;
         if (pending_ns.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h", $time, actual);
            return;
         end
         exp_val = pending_ns.pop_front();
         if (exp_val !== actual) begin
            errors++;
            $display("%0t: result_value expected %h actual %h", $time, exp_val, actual);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [1:0] csr_index;
   logic [63:0] csr_write_data;

   tnc_stream_if #(.Width(2 + 2 * DataWidth)) req_if ();
   tnc_stream_if #(.Width(DataWidth)) rsp_if ();

   tick_nanosecond_converter dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   conversion_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;

   // clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: check each result, then pick ready for the next cycle
   initial rsp_if.ready = 1'b0;
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.data);
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // values near a reference point, or anywhere
   function automatic logic [63:0] pick_value(logic [63:0] anchor);
      case ($urandom_range(3))
         0: return rand64();
         1: return anchor + 64'($urandom_range(100000));
         2: return anchor + {$urandom_range(255), $urandom};
         default: return anchor - 64'($urandom_range(1000));
      endcase
   endfunction

   // one transaction on the request channel
   task automatic send_req(mode_type m, logic [63:0] a, logic [63:0] b);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= {m, a, b};
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(m, a, b);
   endtask

   // register write once the chain has drained
   task automatic write_csr(logic [1:0] idx, logic [63:0] value);
      req_if.valid <= 1'b0;
      while (sb.pending_ns.size() != 0) @(posedge clock);
      repeat (ChainCycles) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   task automatic random_block(int count);
      mode_type m;
      logic [63:0] a;
      logic [63:0] b;
      repeat (count) begin
         m = mode_type'($urandom_range(3));
         case (m)
            MODE_TICK_TO_RT: a = pick_value(sb.tick_base);
            MODE_RT_TO_TICK: a = pick_value(sb.rt_base);
            default: a = pick_value(64'd0);
         endcase
         b = ($urandom_range(3) == 0) ? rand64() : a - pick_value(64'd0);
         if ($urandom_range(15) == 0) b = a;
         send_req(m, a, b);
      end
   endtask

   // limit
   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int phase;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, extremes of every mode
      send_req(MODE_TICK_TO_RT, 64'd0, 64'd0);
      send_req(MODE_TICK_TO_RT, '1, '1);
      send_req(MODE_RT_TO_TICK, 64'd0, '1);
      send_req(MODE_RT_TO_TICK, '1, 64'd0);
      send_req(MODE_DELTA_NS, 64'd5, 64'd5);
      send_req(MODE_DELTA_NS, 64'd4, 64'd5);
      send_req(MODE_DELTA_NS, '1, 64'd0);
      send_req(MODE_NS_TO_TICK, '1, 64'd0);
      send_req(MODE_NS_TO_TICK, 64'd999999999, 64'd0);
      write_csr(REG_TICK_RATE, 64'h3_FFFF_FFFF);
      write_csr(REG_TICK_EPOCH, '1);
      write_csr(REG_RT_EPOCH, 64'h8000_0000_0000_0000);
      send_req(MODE_TICK_TO_RT, '1, 64'd0);
      send_req(MODE_TICK_TO_RT, 64'd0, 64'd0);
      send_req(MODE_RT_TO_TICK, '1, 64'd0);
      send_req(MODE_NS_TO_TICK, '1, 64'd0);
      send_req(MODE_DELTA_NS, '1, 64'd1);
      // zero rate, masking of high bits, ignored index
      write_csr(REG_TICK_RATE, 64'hFFFF_FFFC_0000_0000);
      write_csr(RegUnused, 64'd12345);
      send_req(MODE_TICK_TO_RT, 64'd77, 64'd0);
      send_req(MODE_RT_TO_TICK, 64'd77, 64'd0);
      send_req(MODE_DELTA_NS, 64'd9, 64'd1);
      send_req(MODE_NS_TO_TICK, '1, 64'd0);
      write_csr(REG_TICK_RATE, 64'd1);
      send_req(MODE_TICK_TO_RT, '1, 64'd0);
      send_req(MODE_NS_TO_TICK, '1, 64'd0);

      // random phases with varying settings and idling
      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 54; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 54; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         case (phase)
            0: write_csr(REG_TICK_RATE, 64'd1000000000);
            1: write_csr(REG_TICK_RATE, 64'd1);
            2: write_csr(REG_TICK_RATE, 64'h3_FFFF_FFFF);
            default: write_csr(REG_TICK_RATE,
               {30'd0, 2'($urandom_range(1, 3)), $urandom});
         endcase
         write_csr(REG_TICK_EPOCH, (phase == 0) ? 64'd0 : rand64());
         write_csr(REG_RT_EPOCH, (phase == 7) ? '1 : rand64());
         if (phase == 0) hold_left = 400;
         random_block(200);
      end
      req_if.valid <= 1'b0;

      while (sb.pending_ns.size() != 0) @(posedge clock);
      repeat (ChainCycles + 20) @(posedge clock);
      if (sb.errors == 0 && sb.pending_ns.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

// File: tick_nanosecond_converter.f
design/tnc_pkg.sv
design/tnc_stream_if.sv
design/tnc_div_cell.sv
design/tnc_mid_cell.sv
design/tick_nanosecond_converter.sv
bench/tb_tick_nanosecond_converter.sv
